// ----- rtl/qvr_pkg.sv -----
// Package for the quaternion vector rotator: field widths, derived widths and word types.
package qvr_pkg;

    localparam int VEC_WIDTH  = 24;
    localparam int QUAT_WIDTH = 16;

    // Quaternion fraction bits and the final rounding shift.
    localparam int FRAC_BITS = QUAT_WIDTH - 2;
    localparam int OUT_SHIFT = 2 * FRAC_BITS;

    // First product q_i * v_j and the three-term sums t_j.
    localparam int P1W = VEC_WIDTH + QUAT_WIDTH;
    localparam int TW  = P1W + 2;

    // t_j is split into an unsigned low half and a signed high half.
    localparam int LW  = TW / 2;
    localparam int HW  = TW - LW;
    localparam int LPW = QUAT_WIDTH + LW + 1;
    localparam int HPW = QUAT_WIDTH + HW;

    // Four-term sums of the partial products and the recombined sum.
    localparam int LSW = LPW + 2;
    localparam int HSW = HPW + 2;
    localparam int SW  = HSW + LW;
    localparam int RW  = SW - OUT_SHIFT;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0]  vec_x;
        logic signed [VEC_WIDTH-1:0]  vec_y;
        logic signed [VEC_WIDTH-1:0]  vec_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
    } t_qvr_in;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] rot_x;
        logic signed [VEC_WIDTH-1:0] rot_y;
        logic signed [VEC_WIDTH-1:0] rot_z;
        logic                        saturated;
    } t_qvr_out;

endpackage

// ----- rtl/quaternion_vector_rotate.sv -----
// Top level: pipelined rotation of a 3-vector by a quaternion, q * (0,v) * conj(q).
//
// Usage:
//   Drive one input word on i_word and raise start. The word is taken at every
//   rising edge with start high and busy low. busy never rises: the pipeline
//   takes a new word in every cycle, so throughput is one word per clock.
//   The result word appears on o_word with o_valid high for exactly one cycle.
//   The pipeline has seven register stages: input, first products, t sums,
//   split partial products, partial sums, rounding and saturation. The
//   twelve 16 x 42-bit products of the second Hamilton product are the
//   widest logic, so each t is cut into two halves there.
//   Results leave in the order words came in, one per word.
//   The receiver cannot stall: o_valid is a strobe and the word must be taken
//   in that cycle. Reset (i_rst_n low, synchronous) clears every valid bit,
//   so words in flight are dropped; payload registers keep their contents.
module quaternion_vector_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  qvr_pkg::t_qvr_in   i_word,
    output logic               o_valid,
    output qvr_pkg::t_qvr_out  o_word
);
    import qvr_pkg::*;

    localparam int QW = QUAT_WIDTH;
    localparam int VW = VEC_WIDTH;

    // Second product, per output k and term j: quaternion part index (w,x,y,z = 0..3)
    // multiplying t_j, and whether the term is subtracted.
    localparam logic [1:0] QSEL [3][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                           '{2'd2, 2'd3, 2'd0, 2'd1},
                                           '{2'd3, 2'd2, 2'd1, 2'd0}};
    localparam bit NEG  [3][4] = '{'{1, 0, 1, 0}, '{1, 0, 0, 1}, '{1, 1, 0, 0}};

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (OUT_SHIFT - 1);

    // Stage 0: input capture
    logic    r_v0;
    t_qvr_in r_in0;

    // Stage 1: products of vector and quaternion parts
    logic                  r_v1;
    logic signed [P1W-1:0] r_pr [12];
    logic signed [P1W-1:0] n_pr [12];
    logic signed [QW-1:0]  r_q1 [4];

    // Stage 2: t = q * (0, v)
    logic                 r_v2;
    logic signed [TW-1:0] r_t  [4];
    logic signed [TW-1:0] n_t  [4];
    logic signed [QW-1:0] r_q2 [4];

    // Stage 3: split partial products
    logic                  r_v3;
    logic signed [LPW-1:0] r_plo [3][4];
    logic signed [HPW-1:0] r_phi [3][4];
    logic signed [LPW-1:0] n_plo [3][4];
    logic signed [HPW-1:0] n_phi [3][4];

    // Stage 4: four-term sums of each half
    logic                  r_v4;
    logic signed [LSW-1:0] r_slo [3];
    logic signed [HSW-1:0] r_shi [3];
    logic signed [LSW-1:0] n_slo [3];
    logic signed [HSW-1:0] n_shi [3];

    // Stage 5: recombined, rounded and shifted
    logic                 r_v5;
    logic signed [RW-1:0] r_rnd [3];
    logic signed [RW-1:0] n_rnd [3];

    // Stage 6: saturated output word
    logic                r_v6;
    logic [VW-1:0]       r_rot [3];
    logic [VW-1:0]       n_rot [3];
    logic                r_sat;
    logic                n_sat;

    logic signed [VW-1:0] vx, vy, vz;
    logic signed [QW-1:0] qw, qa, qb, qc;
    logic signed [SW-1:0] full_sum [3];

    assign busy = 1'b0;

    assign vx = r_in0.vec_x;
    assign vy = r_in0.vec_y;
    assign vz = r_in0.vec_z;
    assign qw = r_in0.quat_w;
    assign qa = r_in0.quat_x;
    assign qb = r_in0.quat_y;
    assign qc = r_in0.quat_z;

    // Stage 1 products, ordered as they are summed into t0..t3.
    always_comb begin
        n_pr[0]  = P1W'(qa) * P1W'(vx);
        n_pr[1]  = P1W'(qb) * P1W'(vy);
        n_pr[2]  = P1W'(qc) * P1W'(vz);
        n_pr[3]  = P1W'(qw) * P1W'(vx);
        n_pr[4]  = P1W'(qb) * P1W'(vz);
        n_pr[5]  = P1W'(qc) * P1W'(vy);
        n_pr[6]  = P1W'(qw) * P1W'(vy);
        n_pr[7]  = P1W'(qc) * P1W'(vx);
        n_pr[8]  = P1W'(qa) * P1W'(vz);
        n_pr[9]  = P1W'(qw) * P1W'(vz);
        n_pr[10] = P1W'(qa) * P1W'(vy);
        n_pr[11] = P1W'(qb) * P1W'(vx);
    end

    // Stage 2: three-term sums
    always_comb begin
        n_t[0] = -(TW'(r_pr[0]) + TW'(r_pr[1]) + TW'(r_pr[2]));
        n_t[1] = TW'(r_pr[3]) + TW'(r_pr[4]) - TW'(r_pr[5]);
        n_t[2] = TW'(r_pr[6]) + TW'(r_pr[7]) - TW'(r_pr[8]);
        n_t[3] = TW'(r_pr[9]) + TW'(r_pr[10]) - TW'(r_pr[11]);
    end

    // Stage 3: t_j = hi * 2^LW + lo, lo taken as unsigned, hi as signed
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 4; j++) begin
                n_plo[k][j] = LPW'(r_q2[QSEL[k][j]])
                            * LPW'($signed({1'b0, r_t[j][LW-1:0]}));
                n_phi[k][j] = HPW'(r_q2[QSEL[k][j]])
                            * HPW'($signed(r_t[j][TW-1:LW]));
            end
        end
    end

    // Stage 4: signed four-term sums of each half
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_slo[k] = '0;
            n_shi[k] = '0;
            for (int j = 0; j < 4; j++) begin
                if (NEG[k][j]) begin
                    n_slo[k] = n_slo[k] - LSW'(r_plo[k][j]);
                    n_shi[k] = n_shi[k] - HSW'(r_phi[k][j]);
                end else begin
                    n_slo[k] = n_slo[k] + LSW'(r_plo[k][j]);
                    n_shi[k] = n_shi[k] + HSW'(r_phi[k][j]);
                end
            end
        end
    end

    // Stage 5: recombine halves, add half an LSB, drop the fraction bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            full_sum[k] = $signed({r_shi[k], {LW{1'b0}}}) + SW'(r_slo[k]) + HALF;
            n_rnd[k]    = full_sum[k][SW-1:OUT_SHIFT];
        end
    end

    // Stage 6: clip to the vector width when the upper bits disagree
    always_comb begin
        n_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_rnd[k][RW-1:VW-1] == '0 || r_rnd[k][RW-1:VW-1] == '1) begin
                n_rot[k] = r_rnd[k][VW-1:0];
            end else begin
                n_sat    = 1'b1;
                n_rot[k] = r_rnd[k][RW-1] ? {1'b1, {(VW-1){1'b0}}}
                                          : {1'b0, {(VW-1){1'b1}}};
            end
        end
    end

    // Valid bits: advance one stage each cycle, drop all at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Payload: load only behind a valid word, hold otherwise
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in0 <= i_word;
        end
        if (r_v0) begin
            r_pr    <= n_pr;
            r_q1[0] <= qw;
            r_q1[1] <= qa;
            r_q1[2] <= qb;
            r_q1[3] <= qc;
        end
        if (r_v1) begin
            r_t  <= n_t;
            r_q2 <= r_q1;
        end
        if (r_v2) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
        end
        if (r_v3) begin
            r_slo <= n_slo;
            r_shi <= n_shi;
        end
        if (r_v4) begin
            r_rnd <= n_rnd;
        end
        if (r_v5) begin
            r_rot <= n_rot;
            r_sat <= n_sat;
        end
    end

    assign o_valid          = r_v6;
    assign o_word.rot_x     = r_rot[0];
    assign o_word.rot_y     = r_rot[1];
    assign o_word.rot_z     = r_rot[2];
    assign o_word.saturated = r_sat;

endmodule

// ----- dv/tb.sv -----
// Testbench for quaternion_vector_rotate: directed and random words checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    // Stop the run when this many cycles pass with no word moving on either side.
    localparam int STALL_LIMIT = 400;
    // Cycles to wait after the last result; the pipeline is seven stages deep.
    localparam int TAIL_CYCLES = 12;

    localparam int VEC_MAX = (1 <<< (VEC_WIDTH - 1)) - 1;
    localparam int VEC_MIN = -VEC_MAX - 1;
    localparam longint ROUND_HALF = 64'sd1 <<< (OUT_SHIFT - 1);
    // Q2.14 unity and cos(45 deg) scaled to it.
    localparam int Q_ONE = 1 <<< FRAC_BITS;
    localparam int Q_COS45 = 11585;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_qvr_in   i_word = '0;
    logic      o_valid;
    t_qvr_out  o_word;

    t_qvr_out  pending_rotations[$];
    int        mismatch_count = 0;
    int        stall_cycles = 0;
    bit        sender_gaps_on = 1'b0;

    quaternion_vector_rotate u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predict q * (0,v) * conj(q): exact products, round half up at 2^-28, clip to 24 bits.
    function automatic t_qvr_out rotate_vector(t_qvr_in w);
        longint vx, vy, vz, qw, qa, qb, qc;
        longint s0, s1, s2, s3;
        longint acc[3];
        longint r;
        logic signed [VEC_WIDTH-1:0] comp[3];
        t_qvr_out res;
        vx = longint'($signed(w.vec_x));
        vy = longint'($signed(w.vec_y));
        vz = longint'($signed(w.vec_z));
        qw = longint'($signed(w.quat_w));
        qa = longint'($signed(w.quat_x));
        qb = longint'($signed(w.quat_y));
        qc = longint'($signed(w.quat_z));
        // First Hamilton product, q * (0,v).
        s0 = -(qa * vx + qb * vy + qc * vz);
        s1 = qw * vx + qb * vz - qc * vy;
        s2 = qw * vy + qc * vx - qa * vz;
        s3 = qw * vz + qa * vy - qb * vx;
        // Second product with conj(q); keep the vector part only.
        acc[0] = -qa * s0 + qw * s1 - qc * s2 + qb * s3;
        acc[1] = -qb * s0 + qc * s1 + qw * s2 - qa * s3;
        acc[2] = -qc * s0 - qb * s1 + qa * s2 + qw * s3;
        res.saturated = 1'b0;
        for (int i = 0; i < 3; i++) begin
            r = (acc[i] + ROUND_HALF) >>> OUT_SHIFT;
            if (r > longint'(VEC_MAX)) begin
                r = longint'(VEC_MAX);
                res.saturated = 1'b1;
            end else if (r < longint'(VEC_MIN)) begin
                r = longint'(VEC_MIN);
                res.saturated = 1'b1;
            end
            comp[i] = r[VEC_WIDTH-1:0];
        end
        res.rot_x = comp[0];
        res.rot_y = comp[1];
        res.rot_z = comp[2];
        return res;
    endfunction

    function automatic t_qvr_in make_word(int x, int y, int z, int qw, int qa, int qb, int qc);
        t_qvr_in w;
        w.vec_x  = VEC_WIDTH'(x);
        w.vec_y  = VEC_WIDTH'(y);
        w.vec_z  = VEC_WIDTH'(z);
        w.quat_w = QUAT_WIDTH'(qw);
        w.quat_x = QUAT_WIDTH'(qa);
        w.quat_y = QUAT_WIDTH'(qb);
        w.quat_z = QUAT_WIDTH'(qc);
        return w;
    endfunction

    // Record the expected result of every word the block takes.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pending_rotations.push_back(rotate_vector(i_word));
        end
    end

    // Compare each result strobe against the oldest expected rotation.
    always @(posedge i_clk) begin
        t_qvr_out exp_word;
        if (i_rst_n && o_valid) begin
            if (pending_rotations.size() == 0) begin
                $error("unexpected result word: rot_x %0d rot_y %0d rot_z %0d saturated %0b",
                       o_word.rot_x, o_word.rot_y, o_word.rot_z, o_word.saturated);
                mismatch_count++;
            end else begin
                exp_word = pending_rotations.pop_front();
                if (o_word.rot_x !== exp_word.rot_x) begin
                    $error("rot_x: expected %0d, got %0d", exp_word.rot_x, o_word.rot_x);
                    mismatch_count++;
                end
                if (o_word.rot_y !== exp_word.rot_y) begin
                    $error("rot_y: expected %0d, got %0d", exp_word.rot_y, o_word.rot_y);
                    mismatch_count++;
                end
                if (o_word.rot_z !== exp_word.rot_z) begin
                    $error("rot_z: expected %0d, got %0d", exp_word.rot_z, o_word.rot_z);
                    mismatch_count++;
                end
                if (o_word.saturated !== exp_word.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           exp_word.saturated, o_word.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no word moves in or out.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Send one word: maybe hold off for a random burst, then hold start until the block takes it.
    task automatic issue_word(t_qvr_in w);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and wait until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rotations.size() != 0);
    endtask

    // Identity, null and axis rotations, full-scale extremes, saturation and rounding ties.
    task automatic test_directed();
        sender_gaps_on = 1'b0;
        issue_word(make_word(VEC_MAX, VEC_MIN, 0, Q_ONE, 0, 0, 0));
        issue_word(make_word(VEC_MIN, VEC_MAX, -1, Q_ONE, 0, 0, 0));
        issue_word(make_word(VEC_MAX, VEC_MAX, VEC_MAX, 0, 0, 0, 0));
        issue_word(make_word(1, 2, 3, -Q_ONE, 0, 0, 0));
        // Quarter turns about each axis.
        issue_word(make_word(1000000, 0, 0, Q_COS45, Q_COS45, 0, 0));
        issue_word(make_word(0, 1000000, 0, Q_COS45, Q_COS45, 0, 0));
        issue_word(make_word(0, 0, 1000000, Q_COS45, 0, Q_COS45, 0));
        issue_word(make_word(1000000, 2000000, 3000000, Q_COS45, 0, 0, Q_COS45));
        // Half turn about x: negating the minimum overflows and must clip.
        issue_word(make_word(VEC_MIN, VEC_MIN, VEC_MIN, 0, Q_ONE, 0, 0));
        // Quaternion extremes with vector extremes.
        issue_word(make_word(VEC_MAX, VEC_MAX, VEC_MAX, 32767, 32767, 32767, 32767));
        issue_word(make_word(VEC_MIN, VEC_MIN, VEC_MIN, -32768, -32768, -32768, -32768));
        issue_word(make_word(VEC_MAX, VEC_MIN, VEC_MAX, 32767, -32768, 32767, -32768));
        issue_word(make_word(VEC_MIN, VEC_MAX, VEC_MIN, -32768, 32767, -32768, 32767));
        // Rounding ties: w = 256 scales v by 2^-12, so +-2048 lands on exactly one half.
        issue_word(make_word(2048, -2048, 6144, 256, 0, 0, 0));
        issue_word(make_word(-6144, 2047, 2049, 256, 0, 0, 0));
        issue_word(make_word(-2049, -2047, 4096, 0, 256, 0, 0));
        // Tiny quaternion: everything rounds to zero.
        issue_word(make_word(VEC_MAX, VEC_MIN, 134217, 1, 0, 0, 0));
        // Non-unit norm scales by |q|^2 and pushes past full scale.
        issue_word(make_word(2097152, -2097152, 3000000, 32767, 0, 0, 0));
        issue_word(make_word(-2097152, 2097151, -1, 0, 0, -32768, 0));
        issue_word(make_word(0, 0, 0, -32768, -32768, -32768, -32768));
    endtask

    // Fully random words: every bit of every field, saturation common.
    task automatic test_random_bits(int count);
        bit [159:0] noise;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) sender_gaps_on = ($urandom_range(0, 1) != 0);
            noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            issue_word(t_qvr_in'(noise[$bits(t_qvr_in)-1:0]));
        end
    endtask

    // Near-unit quaternions with vectors of mixed magnitude, as a real orientation stream.
    task automatic test_unit_rotations(int count, bit pause_midway, bit gaps_allowed);
        int raw[4];
        int span;
        real norm;
        real scale;
        t_qvr_in w;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) sender_gaps_on = gaps_allowed && ($urandom_range(0, 1) != 0);
            if (pause_midway && n == count / 2) drain_results();
            foreach (raw[k]) raw[k] = int'($urandom_range(0, 65534)) - 32767;
            norm = $sqrt($itor(raw[0]) * raw[0] + $itor(raw[1]) * raw[1]
                         + $itor(raw[2]) * raw[2] + $itor(raw[3]) * raw[3]);
            case ($urandom_range(0, 3))
                0: span = 255;
                1: span = 65535;
                default: span = 8388607;
            endcase
            w.vec_x = VEC_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
            w.vec_y = VEC_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
            w.vec_z = VEC_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
            if (norm < 1.0) begin
                w.quat_w = QUAT_WIDTH'(Q_ONE);
                w.quat_x = '0;
                w.quat_y = '0;
                w.quat_z = '0;
            end else begin
                scale = $itor(Q_ONE) / norm;
                w.quat_w = QUAT_WIDTH'($rtoi(raw[0] * scale));
                w.quat_x = QUAT_WIDTH'($rtoi(raw[1] * scale));
                w.quat_y = QUAT_WIDTH'($rtoi(raw[2] * scale));
                w.quat_z = QUAT_WIDTH'($rtoi(raw[3] * scale));
            end
            issue_word(w);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_bits(450);
        test_unit_rotations(600, 1'b1, 1'b1);
        // Close with back-to-back words: no gaps from here on.
        sender_gaps_on = 1'b0;
        test_unit_rotations(300, 1'b0, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rotations.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate.sv
dv/tb.sv
